[rtl/mpfd_pkg.sv]
package mpfd_pkg;

   localparam int Width  = 128;
   localparam int Height = 64;
   localparam int Pages  = 8;
   localparam int Depth  = Pages * Width;
   localparam int XW     = $clog2(Width);
   localparam int PW     = $clog2(Pages);
   localparam int AW     = $clog2(Depth);

   localparam logic [7:0] ALL_ONES = 8'hFF;
   localparam logic [7:0] ROW_MASK = 8'h07;
   localparam logic [7:0] ZERO     = 8'h00;

   typedef enum logic [2:0] {
      KIND_PIXEL    = 3'd0,
      KIND_HLINE    = 3'd1,
      KIND_VLINE    = 3'd2,
      KIND_RECT     = 3'd3,
      KIND_FILLRECT = 3'd4,
      KIND_FILLALL  = 3'd5,
      KIND_COLUMN   = 3'd6,
      KIND_READ     = 3'd7
   } kind_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] x_first;
      logic [7:0] y_first;
      logic [7:0] x_second;
      logic [7:0] y_second;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       address_ok;
   } rsp_type;

   // Sequencer states: CLEAR sweeps the store after reset.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_WRITE,
      ST_FILL,
      ST_RESP
   } state_type;

endpackage

[rtl/mono_page_framebuffer_draw_top.sv]
// Channel | Dir | Ports                         | Moves
// req     | in  | req_valid req_stall req_data  | one command word
// rsp     | out | rsp_valid rsp_stall rsp_data  | one read-result word
//
// Every byte a drawing command touches takes a read-modify-write through one
// memory port, in the states READ, MODIFY and WRITE; a read command passes READ
// and MODIFY, then RESP hands off the result, and fill all writes every byte directly.
// After reset a clearing pass writes zero to all 1024 bytes before req_stall drops.
// req_stall is high whenever a command is in progress; a read result holds
// on rsp_data until rsp_stall is low, and a new command may start meanwhile.
module mono_page_framebuffer_draw_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mpfd_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mpfd_pkg::rsp_type   rsp_data
);
   import mpfd_pkg::*;

   logic [7:0] mem [Depth];

   state_type  state_ff, state_in;
   req_type    cmd_ff, cmd_in;
   // Walk position and the current segment within a rectangle outline
   logic [8:0] px_ff, px_in, py_ff, py_in;
   logic [8:0] xend_ff, xend_in, yend_ff, yend_in;
   logic [1:0] seg_ff, seg_in;
   logic       hi_ff, hi_in;       // second byte of a split column
   logic [AW:0] cnt_ff, cnt_in;
   logic [7:0] rd_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       rspv_ff, rspv_in;

   logic       we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0] wdata;

   // Memory with registered read
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // Byte address and bit for the current walk point
   logic [8:0] cx, cy;
   logic       inb;
   logic [2:0] off;
   logic [PW:0] page;
   logic [7:0] bitm;
   always_comb begin
      cx = px_ff;
      cy = py_ff;
      off = cy[2:0];
      page = (PW+1)'(cy >> 3) + (PW+1)'(hi_ff);
      inb = (cx < 9'(Width)) && (cy < 9'(Height)) && (page < (PW+1)'(Pages));
      raddr = AW'({page[PW-1:0], cx[XW-1:0]});
      bitm = 8'd1 << off;
   end

   // Sequencer
   logic [8:0] lo, hi2;
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      px_in = px_ff; py_in = py_ff; xend_in = xend_ff; yend_in = yend_ff;
      seg_in = seg_ff; hi_in = hi_ff; cnt_in = cnt_ff;
      rsp_in = rsp_ff; rspv_in = rspv_ff;
      we = 1'b0; waddr = raddr; wdata = ZERO;
      req_stall = 1'b1;
      lo = 9'd0; hi2 = 9'd0;
      if (rspv_ff && !rsp_stall) rspv_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            we = 1'b1; waddr = cnt_ff[AW-1:0]; wdata = ZERO;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(Depth - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in = req_data;
               hi_in = 1'b0; seg_in = 2'd0; cnt_in = '0;
               px_in = {1'b0, req_data.x_first};
               py_in = {1'b0, req_data.y_first};
               xend_in = px_in; yend_in = py_in;
               state_in = ST_READ;
               unique case (kind_type'(req_data.kind))
                  KIND_HLINE, KIND_RECT: begin
                     lo = (req_data.x_first < req_data.x_second) ?
                          9'(req_data.x_first) : 9'(req_data.x_second);
                     hi2 = (req_data.x_first < req_data.x_second) ?
                          9'(req_data.x_second) : 9'(req_data.x_first);
                     px_in = lo; xend_in = hi2;
                  end
                  KIND_VLINE: begin
                     lo = (req_data.y_first < req_data.y_second) ?
                          9'(req_data.y_first) : 9'(req_data.y_second);
                     hi2 = (req_data.y_first < req_data.y_second) ?
                          9'(req_data.y_second) : 9'(req_data.y_first);
                     py_in = lo; yend_in = hi2;
                  end
                  KIND_FILLRECT: begin
                     xend_in = 9'(req_data.x_second);
                     yend_in = 9'(req_data.y_second);
                     if (req_data.x_first > req_data.x_second ||
                         req_data.y_first > req_data.y_second) state_in = ST_IDLE;
                  end
                  KIND_FILLALL: state_in = ST_FILL;
                  KIND_READ: begin
                     px_in = {1'b0, req_data.x_first};
                     py_in = {req_data.y_first, 3'd0} > 9'h1FF ? 9'h1FF :
                             ((req_data.y_first < 8'(Pages)) ?
                              9'({req_data.y_first, 3'd0}) : 9'h1FF);
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: state_in = ST_MODIFY;
         ST_MODIFY: begin
            state_in = ST_WRITE;
            if (kind_type'(cmd_ff.kind) == KIND_READ) state_in = ST_RESP;
         end
         ST_WRITE: begin
            we = inb;
            unique case (kind_type'(cmd_ff.kind))
               KIND_PIXEL: wdata = (cmd_ff.value != ZERO) ? (rd_ff | bitm)
                                                          : (rd_ff & ~bitm);
               KIND_COLUMN: begin
                  if (!hi_ff)
                     wdata = (rd_ff & ~(ALL_ONES << off)) | (cmd_ff.value << off);
                  else
                     wdata = (rd_ff & ~(ALL_ONES >> (4'd8 - 4'(off))))
                           | (cmd_ff.value >> (4'd8 - 4'(off)));
                  if (!hi_ff && off == 3'd0) wdata = cmd_ff.value;
               end
               default: wdata = rd_ff | bitm;
            endcase
            state_in = ST_READ;
            unique case (kind_type'(cmd_ff.kind))
               KIND_PIXEL: state_in = ST_IDLE;
               KIND_COLUMN: begin
                  // skip the whole command if the first byte lies outside
                  if (!hi_ff && inb && off != 3'd0) hi_in = 1'b1;
                  else state_in = ST_IDLE;
               end
               KIND_HLINE: begin
                  if (px_ff == xend_ff) state_in = ST_IDLE;
                  else px_in = px_ff + 1'b1;
               end
               KIND_VLINE: begin
                  if (py_ff == yend_ff) state_in = ST_IDLE;
                  else py_in = py_ff + 1'b1;
               end
               KIND_FILLRECT: begin
                  if (px_ff != xend_ff) px_in = px_ff + 1'b1;
                  else if (py_ff != yend_ff) begin
                     px_in = 9'(cmd_ff.x_first); py_in = py_ff + 1'b1;
                  end else state_in = ST_IDLE;
               end
               KIND_RECT: begin
                  // Segments: row at y_first, row at y_second, column at x_first, column at x_second
                  if (seg_ff[1] == 1'b0 && px_ff != xend_ff) px_in = px_ff + 1'b1;
                  else if (seg_ff[1] == 1'b1 && py_ff != yend_ff) py_in = py_ff + 1'b1;
                  else begin
                     seg_in = seg_ff + 1'b1;
                     if (seg_ff == 2'd3) state_in = ST_IDLE;
                     lo = (cmd_ff.x_first < cmd_ff.x_second) ?
                          9'(cmd_ff.x_first) : 9'(cmd_ff.x_second);
                     hi2 = (cmd_ff.y_first < cmd_ff.y_second) ?
                          9'(cmd_ff.y_first) : 9'(cmd_ff.y_second);
                     unique case (seg_ff)
                        2'd0: begin px_in = lo; py_in = 9'(cmd_ff.y_second); end
                        2'd1: begin
                           px_in = 9'(cmd_ff.x_first); py_in = hi2;
                           yend_in = (cmd_ff.y_first < cmd_ff.y_second) ?
                                     9'(cmd_ff.y_second) : 9'(cmd_ff.y_first);
                        end
                        2'd2: begin px_in = 9'(cmd_ff.x_second); py_in = hi2; end
                        default: ;
                     endcase
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_FILL: begin
            we = 1'b1; waddr = cnt_ff[AW-1:0]; wdata = cmd_ff.value;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(Depth - 1)) state_in = ST_IDLE;
         end
         ST_RESP: begin
            // Load the result register once it is free or being drained
            if (!rspv_ff || !rsp_stall) begin
               rsp_in.address_ok = inb;
               rsp_in.read_data = inb ? rd_ff : ZERO;
               rspv_in = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         rspv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rspv_ff <= rspv_in;
      end
      cmd_ff <= cmd_in; px_ff <= px_in; py_ff <= py_in;
      xend_ff <= xend_in; yend_ff <= yend_in; seg_ff <= seg_in;
      hi_ff <= hi_in; rsp_ff <= rsp_in;
   end

   assign rsp_valid = rspv_ff;
   assign rsp_data = rsp_ff;

   // Commands are taken only in idle
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> state_ff == ST_IDLE) else $error("take out of idle");
   // A result appears only after a read command
   a_rsp_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_RESP) else $error("stray result");
   // Writes never fire while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !we) else $error("write in idle");
endmodule

[sim/tb_mono_page_framebuffer_draw_top.sv]
`timescale 1ns / 100ps

module tb_mono_page_framebuffer_draw_top;
   import mpfd_pkg::*;

   localparam int WatchLimit = 1000000;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   req_type   req_data = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b1;
   rsp_type   rsp_data;

   // shadow of the frame buffer
   logic [7:0] shadow_store [Depth];
   rsp_type    pending_reads [$];
   int         mismatch_count = 0;
   int         send_idle_pct = 26;
   int         recv_idle_pct = 48;
   bit         recv_hold = 1'b0;
   int         quiet_cycles = 0;

   // directed command rows; check_row marks a read with a typed-in answer
   typedef struct {
      req_type cmd;
      bit      check_row;
      rsp_type answer;
   } row_type;

   row_type directed_rows [$];

   mono_page_framebuffer_draw_top DUT (.*);

   always #5 clock = ~clock;

   function automatic req_type make_cmd(kind_type k, int xa, int ya, int xb, int yb, int v);
      req_type c;
      c.kind = k; c.x_first = 8'(xa); c.y_first = 8'(ya);
      c.x_second = 8'(xb); c.y_second = 8'(yb); c.value = 8'(v);
      return c;
   endfunction

   function automatic rsp_type make_rsp(int d, int ok);
      rsp_type r;
      r.read_data = 8'(d); r.address_ok = 1'(ok);
      return r;
   endfunction

   function automatic void plot_shadow(int x, int y, bit on);
      int pg;
      pg = y >> 3;
      if (x >= Width || y >= Height || pg >= Pages) return;
      if (on) shadow_store[pg * Width + x] |= 8'(1 << (y & 7));
      else    shadow_store[pg * Width + x] &= ~8'(1 << (y & 7));
   endfunction

   function automatic void hline_shadow(int xa, int xb, int y);
      int lo, hi;
      lo = xa < xb ? xa : xb;
      hi = xa < xb ? xb : xa;
      for (int x = lo; x <= hi; x++) plot_shadow(x, y, 1'b1);
   endfunction

   function automatic void vline_shadow(int x, int ya, int yb);
      int lo, hi;
      lo = ya < yb ? ya : yb;
      hi = ya < yb ? yb : ya;
      for (int y = lo; y <= hi; y++) plot_shadow(x, y, 1'b1);
   endfunction

   function automatic void column_shadow(int x, int y, logic [7:0] d);
      int pg, off;
      logic [7:0] m;
      pg = y >> 3;
      off = y & 7;
      if (x >= Width || y >= Height || pg >= Pages) return;
      if (off == 0) begin
         shadow_store[pg * Width + x] = d;
         return;
      end
      m = 8'hFF << off;
      shadow_store[pg * Width + x] = (shadow_store[pg * Width + x] & ~m) | 8'(d << off);
      if (pg + 1 < Pages) begin
         m = 8'hFF >> (8 - off);
         shadow_store[(pg + 1) * Width + x] =
            (shadow_store[(pg + 1) * Width + x] & ~m) | 8'(d >> (8 - off));
      end
   endfunction

   // apply one command to the shadow, return 1 with the answer for a read
   function automatic bit apply_draw(req_type c, output rsp_type r);
      r = '0;
      case (kind_type'(c.kind))
         KIND_PIXEL:  plot_shadow(c.x_first, c.y_first, c.value != 0);
         KIND_HLINE:  hline_shadow(c.x_first, c.x_second, c.y_first);
         KIND_VLINE:  vline_shadow(c.x_first, c.y_first, c.y_second);
         KIND_RECT: begin
            hline_shadow(c.x_first, c.x_second, c.y_first);
            hline_shadow(c.x_first, c.x_second, c.y_second);
            vline_shadow(c.x_first, c.y_first, c.y_second);
            vline_shadow(c.x_second, c.y_first, c.y_second);
         end
         KIND_FILLRECT: begin
            if (c.x_first <= c.x_second && c.y_first <= c.y_second)
               for (int y = c.y_first; y <= c.y_second; y++)
                  hline_shadow(c.x_first, c.x_second, y);
         end
         KIND_FILLALL: foreach (shadow_store[i]) shadow_store[i] = c.value;
         KIND_COLUMN: column_shadow(c.x_first, c.y_first, c.value);
         default: begin
            if (c.x_first < Width && c.y_first < Pages) begin
               r.read_data = shadow_store[c.y_first * Width + c.x_first];
               r.address_ok = 1'b1;
            end
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   // drive one word and hold it until accepted; valid drops only on an idle cycle
   task automatic send_word(req_type c);
      while (($urandom % 100) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= c;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // small coordinates mostly, so lines stay short and hit the panel
   function automatic int pick_coord(int span);
      int r;
      r = $urandom % 10;
      if (r == 0) return $urandom_range(0, 255);
      if (r == 1) return span - 1 + $urandom_range(0, 2);
      return $urandom_range(0, span - 1);
   endfunction

   function automatic req_type random_cmd();
      req_type c;
      int r, xa, ya;
      c.value = 8'($urandom);
      xa = pick_coord(Width);
      ya = pick_coord(Height);
      c.x_first = 8'(xa); c.y_first = 8'(ya);
      c.x_second = 8'(xa + $urandom_range(0, 12) - 6);
      c.y_second = 8'(ya + $urandom_range(0, 12) - 6);
      if ($urandom % 8 == 0) begin
         c.x_second = 8'($urandom); c.y_second = 8'($urandom);
         c.x_first = 8'($urandom);
      end
      r = $urandom % 100;
      if (r < 14)      c.kind = KIND_PIXEL;
      else if (r < 22) c.kind = KIND_HLINE;
      else if (r < 30) c.kind = KIND_VLINE;
      else if (r < 36) c.kind = KIND_RECT;
      else if (r < 42) c.kind = KIND_FILLRECT;
      else if (r < 44) c.kind = KIND_FILLALL;
      else if (r < 62) c.kind = KIND_COLUMN;
      else begin
         c.kind = KIND_READ;
         c.y_first = ($urandom % 8 == 0) ? 8'($urandom) : 8'($urandom_range(0, Pages - 1));
      end
      // clip wide random lines to keep runtime bounded
      if (c.kind inside {KIND_HLINE, KIND_RECT, KIND_FILLRECT} && $urandom % 20 != 0
          && c.x_second > c.x_first + 16) c.x_second = 8'(c.x_first + 16);
      if (c.kind inside {KIND_VLINE, KIND_RECT, KIND_FILLRECT} && $urandom % 20 != 0
          && c.y_second > c.y_first + 16) c.y_second = 8'(c.y_first + 16);
      return c;
   endfunction

   // receiver: random stall, with a long hold when asked
   always @(negedge clock) begin
      if (recv_hold) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom % 100) < recv_idle_pct;
   end

   // check each read result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reads.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result word %h", rsp_data);
         end else begin
            rsp_type want;
            want = pending_reads.pop_front();
            if (rsp_data.read_data !== want.read_data
                || rsp_data.address_ok !== want.address_ok) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("read mismatch: expected data %h ok %b, got data %h ok %b",
                           want.read_data, want.address_ok,
                           rsp_data.read_data, rsp_data.address_ok);
            end
         end
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic issue(req_type c, bit check_row, rsp_type answer);
      rsp_type r;
      if (apply_draw(c, r)) begin
         if (check_row && r !== answer) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("predictor disagrees with table: %h vs %h", r, answer);
         end
         pending_reads.push_back(r);
      end
      send_word(c);
   endtask

   task automatic add_row(req_type c, bit chk = 0, rsp_type a = '0);
      row_type rw;
      rw.cmd = c; rw.check_row = chk; rw.answer = a;
      directed_rows.push_back(rw);
   endtask

   initial begin
      foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      add_row(make_cmd(KIND_READ, 0, 0, 0, 0, 0), 1, make_rsp(8'h00, 1));
      add_row(make_cmd(KIND_READ, 127, 7, 0, 0, 0), 1, make_rsp(8'h00, 1));
      add_row(make_cmd(KIND_READ, 128, 0, 0, 0, 0), 1, make_rsp(8'h00, 0));
      add_row(make_cmd(KIND_READ, 0, 8, 0, 0, 0), 1, make_rsp(8'h00, 0));
      add_row(make_cmd(KIND_PIXEL, 0, 0, 0, 0, 1));
      add_row(make_cmd(KIND_PIXEL, 127, 63, 255, 255, 255));
      add_row(make_cmd(KIND_PIXEL, 255, 255, 0, 0, 1));
      add_row(make_cmd(KIND_READ, 0, 0, 0, 0, 0), 1, make_rsp(8'h01, 1));
      add_row(make_cmd(KIND_READ, 127, 7, 0, 0, 0), 1, make_rsp(8'h80, 1));
      add_row(make_cmd(KIND_PIXEL, 0, 0, 0, 0, 0));
      add_row(make_cmd(KIND_HLINE, 20, 3, 10, 0, 0));
      add_row(make_cmd(KIND_HLINE, 120, 9, 255, 0, 0));
      add_row(make_cmd(KIND_VLINE, 5, 20, 2, 0, 0));
      add_row(make_cmd(KIND_VLINE, 6, 60, 0, 255, 0));
      add_row(make_cmd(KIND_RECT, 30, 40, 22, 33, 0));
      add_row(make_cmd(KIND_FILLRECT, 50, 10, 60, 20, 0));
      add_row(make_cmd(KIND_FILLRECT, 60, 10, 50, 20, 0));
      add_row(make_cmd(KIND_COLUMN, 70, 16, 0, 0, 8'hA5));
      add_row(make_cmd(KIND_COLUMN, 71, 19, 0, 0, 8'hFF));
      add_row(make_cmd(KIND_COLUMN, 72, 61, 0, 0, 8'hC3));
      add_row(make_cmd(KIND_COLUMN, 128, 0, 0, 0, 8'hFF));
      add_row(make_cmd(KIND_READ, 71, 3, 0, 0, 0));
      add_row(make_cmd(KIND_FILLALL, 0, 0, 0, 0, 8'h5A));
      add_row(make_cmd(KIND_READ, 64, 4, 0, 0, 0), 1, make_rsp(8'h5A, 1));
      add_row(make_cmd(KIND_FILLALL, 0, 0, 0, 0, 8'h00));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue(directed_rows[i].cmd, directed_rows[i].check_row, directed_rows[i].answer);

      // random phases: receiver idles more, then sender idles more, then neither
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 48 : 0;
         recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 26 : 0;
         if (phase == 2) begin
            // hold the receiver off while reads keep arriving
            fork
               begin
                  recv_hold = 1'b1;
                  repeat (300) @(negedge clock);
                  recv_hold = 1'b0;
               end
               for (int k = 0; k < 6; k++)
                  issue(make_cmd(KIND_READ, $urandom_range(0, 127), $urandom_range(0, 7),
                                 0, 0, 0), 0, '0);
            join
         end
         for (int n = 0; n < 140; n++) issue(random_cmd(), 0, '0);
      end
      req_valid <= 1'b0;

      // drain
      fork
         wait (pending_reads.size() == 0);
         repeat (WatchLimit) @(posedge clock);
      join_any
      disable fork;
      repeat (20) @(posedge clock);
      if (pending_reads.size() == 0 && mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
